FILE: hw/rtl/stereo_linear_fade_out_assert.svh
// Assertion macros used by the top-level RTL of the fade-out block.
`ifndef STEREO_LINEAR_FADE_OUT_ASSERT_SVH
`define STEREO_LINEAR_FADE_OUT_ASSERT_SVH
`ifndef SYNTH
`define SLFO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SLFO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SLFO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLFO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/slfo_pkg.sv
`timescale 1ns / 1ps
package slfo_pkg;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int UNIT_W = 16;
	localparam int IDX_W  = 26;

	localparam logic [1:0] REG_FADE_START  = 2'd0;
	localparam logic [1:0] REG_FADE_LENGTH = 2'd1;
	localparam logic [1:0] REG_CLIP_FRAMES = 2'd2;

	typedef struct packed {
		logic [UNIT_W-1:0] fade_start_units;
		logic [UNIT_W-1:0] fade_length_units;
		logic [IDX_W-1:0]  clip_frames;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic scale;
		logic decide;
		logic mul;
		logic div_load;
		logic div_step;
		logic div_store;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic fade;
		logic ch;
		logic div_last;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SCALE  = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_MUL    = 8'b0000_1000,
		ST_LOAD   = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_STORE  = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;
endpackage

FILE: hw/rtl/slfo_in_if.sv
`timescale 1ns / 1ps
interface slfo_in_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic                first_frame;
	logic signed [W-1:0] left_in;
	logic signed [W-1:0] right_in;

	modport source (output valid, output first_frame, output left_in, output right_in,
		input ready);
	modport sink (input valid, input first_frame, input left_in, input right_in,
		output ready);
endinterface

FILE: hw/rtl/slfo_out_if.sv
`timescale 1ns / 1ps
interface slfo_out_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] left_out;
	logic signed [W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: hw/rtl/slfo_cfg.sv
`timescale 1ns / 1ps
module slfo_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [slfo_pkg::ADDR_W-1:0] paddr,
	input  logic [slfo_pkg::DATA_W-1:0] pwdata,
	output logic [slfo_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output slfo_pkg::cfg_t             cfg
);
	import slfo_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FADE_START:  cfg_q.fade_start_units  <= pwdata[UNIT_W-1:0];
				REG_FADE_LENGTH: cfg_q.fade_length_units <= pwdata[UNIT_W-1:0];
				REG_CLIP_FRAMES: cfg_q.clip_frames       <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FADE_START:  prdata = DATA_W'(cfg_q.fade_start_units);
			REG_FADE_LENGTH: prdata = DATA_W'(cfg_q.fade_length_units);
			REG_CLIP_FRAMES: prdata = DATA_W'(cfg_q.clip_frames);
			default:         prdata = '0;
		endcase
	end
endmodule

FILE: hw/rtl/slfo_ctrl.sv
`timescale 1ns / 1ps
module slfo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  slfo_pkg::dp_stat_t  stat,
	output slfo_pkg::dp_cmd_t   cmd
);
	import slfo_pkg::*;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.accept    = in_valid && in_ready;
		cmd.scale     = (state_q == ST_SCALE);
		cmd.decide    = (state_q == ST_DECIDE);
		cmd.mul       = (state_q == ST_MUL) && stat.fade;
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_store = (state_q == ST_STORE);
		cmd.out_load  = (state_q == ST_OUT) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCALE;
			end
			ST_SCALE:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_MUL;
			ST_MUL: begin
				state_d = stat.fade ? ST_LOAD : ST_OUT;
			end
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = stat.ch ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: hw/rtl/slfo_dp.sv
`timescale 1ns / 1ps
module slfo_dp #(
	parameter int FRAMES_PER_UNIT = 441,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slfo_pkg::cfg_t                cfg,
	input  slfo_pkg::dp_cmd_t             cmd,
	output slfo_pkg::dp_stat_t            stat,
	input  logic                          first_frame,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);
	import slfo_pkg::*;

	localparam int FPU_W  = $clog2(FRAMES_PER_UNIT + 1);
	localparam int PROD_W = UNIT_W + FPU_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int CMP_W  = (SUM_W > IDX_W) ? SUM_W : IDX_W;
	localparam int MUL_W  = SAMPLE_BITS + PROD_W;
	localparam int CNT_W  = $clog2(SAMPLE_BITS);
	localparam logic [FPU_W-1:0] FPU       = FPU_W'(FRAMES_PER_UNIT);
	localparam logic [IDX_W-1:0] INDEX_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SAMPLE_BITS - 1);

	logic [IDX_W-1:0]              frame_idx_q;
	logic [IDX_W-1:0]              n_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic [PROD_W-1:0]             start_q;
	logic [PROD_W-1:0]             len_q;
	logic [PROD_W-1:0]             gain_q;
	logic                          fade_q;
	logic                          ch_q;
	logic [MUL_W-1:0]              prod_q;
	logic [PROD_W-1:0]             rem_q;
	logic [SAMPLE_BITS-1:0]        shr_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [SAMPLE_BITS-1:0] res_l_q;
	logic signed [SAMPLE_BITS-1:0] res_r_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q;
	logic signed [SAMPLE_BITS-1:0] out_r_q;

	logic [IDX_W-1:0]       n_d;
	logic [CMP_W-1:0]       end_w;
	logic [CMP_W-1:0]       n_w;
	logic [CMP_W-1:0]       start_w;
	logic [CMP_W-1:0]       len_w;
	logic [CMP_W-1:0]       k_w;
	logic                   active;
	logic                   in_fade;
	logic [SAMPLE_BITS-1:0] x_u;
	logic [SAMPLE_BITS-1:0] mag;
	logic [PROD_W+1:0]      trial;
	logic                   ge;
	logic [SAMPLE_BITS-1:0] quot_s;

	assign n_d     = first_frame ? '0 : frame_idx_q;
	assign n_w     = CMP_W'(n_q);
	assign start_w = CMP_W'(start_q);
	assign len_w   = CMP_W'(len_q);
	assign end_w   = start_w + len_w;
	assign k_w     = n_w - start_w;
	assign active  = (CMP_W'(cfg.clip_frames) >= end_w) && (n_w >= start_w);
	assign in_fade = k_w < len_w;

	assign x_u   = ch_q ? right_q : left_q;
	assign mag   = x_u[SAMPLE_BITS-1] ? (~x_u + 1'b1) : x_u;
	assign trial = {1'b0, rem_q, shr_q[SAMPLE_BITS-1]} - {2'b00, len_q};
	assign ge    = !trial[PROD_W+1];
	assign quot_s = x_u[SAMPLE_BITS-1] ? (~shr_q + 1'b1) : shr_q;

	assign stat.fade     = fade_q;
	assign stat.ch       = ch_q;
	assign stat.div_last = (cnt_q == CNT_LAST);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q <= '0;
			ch_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				frame_idx_q <= (n_d == INDEX_MAX) ? n_d : n_d + 1'b1;
			end
			if (cmd.decide) begin
				ch_q <= 1'b0;
			end else if (cmd.div_store) begin
				ch_q <= ~ch_q;
			end
			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q     <= n_d;
			left_q  <= left_in;
			right_q <= right_in;
		end
		if (cmd.scale) begin
			start_q <= PROD_W'(cfg.fade_start_units) * PROD_W'(FPU);
			len_q   <= PROD_W'(cfg.fade_length_units) * PROD_W'(FPU);
		end
		if (cmd.decide) begin
			fade_q  <= active && in_fade;
			gain_q  <= PROD_W'(len_w - k_w);
			res_l_q <= (active && !in_fade) ? '0 : left_q;
			res_r_q <= (active && !in_fade) ? '0 : right_q;
		end
		if (cmd.mul) begin
			prod_q <= MUL_W'(mag) * MUL_W'(gain_q);
		end
		if (cmd.div_load) begin
			rem_q <= prod_q[MUL_W-1:SAMPLE_BITS];
			shr_q <= prod_q[SAMPLE_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[PROD_W-1:0] : {rem_q[PROD_W-2:0], shr_q[SAMPLE_BITS-1]};
			shr_q <= {shr_q[SAMPLE_BITS-2:0], ge};
		end
		if (cmd.div_store) begin
			if (ch_q) begin
				res_r_q <= quot_s;
			end else begin
				res_l_q <= quot_s;
			end
		end
		if (cmd.out_load) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end
endmodule

FILE: hw/rtl/stereo_linear_fade_out.sv
`timescale 1ns / 1ps
// Channel  Role    Contents
// frame    sink    first_frame, left_in, right_in
// faded    source  left_out, right_out
// APB      slave   fade_start_units, fade_length_units, clip_frames
//
// A frame outside the fade goes from acceptance through scaling and the fade decision to
// the result register; a faded frame also passes the shared restoring divider, one quotient
// bit per cycle for the left and then the right sample. A new frame is taken only once
// the last result has been loaded into the result register.
// Reset clears the configuration registers, the frame count and the result valid flag at once.
// A held result does not block the next frame; its result waits for the result register.
module stereo_linear_fade_out #(
	parameter int FRAMES_PER_UNIT = 441,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	slfo_in_if.sink                     frame,
	slfo_out_if.source                  faded,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [slfo_pkg::ADDR_W-1:0] paddr,
	input  logic [slfo_pkg::DATA_W-1:0] pwdata,
	output logic [slfo_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import slfo_pkg::*;
	`include "stereo_linear_fade_out_assert.svh"

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	slfo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_ready (frame.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slfo_dp #(
		.FRAMES_PER_UNIT (FRAMES_PER_UNIT),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.first_frame (frame.first_frame),
		.left_in     (frame.left_in),
		.right_in    (frame.right_in),
		.out_valid   (faded.valid),
		.out_ready   (faded.ready),
		.left_out    (faded.left_out),
		.right_out   (faded.right_out)
	);

	`SLFO_ASSERT_NXT(a_busy_after_accept, clk, arst_n, frame.valid && frame.ready, !frame.ready)
	`SLFO_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, stat.out_free)
	`SLFO_ASSERT_IMP(a_valid_from_load, clk, arst_n, $rose(faded.valid), $past(cmd.out_load))
endmodule

FILE: bench/stereo_linear_fade_out_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic signed [15:0] left;
	logic signed [15:0] right;
} stereo_frame_t;

class fade_scoreboard;
	int frames_per_unit;
	logic [15:0] start_units;
	logic [15:0] length_units;
	logic [25:0] clip_frames;
	longint frame_index;
	stereo_frame_t pending_frames[$];
	int failures;
	int frames_seen;
	int results_checked;

	function new(int fpu);
		frames_per_unit = fpu;
		start_units = '0;
		length_units = '0;
		clip_frames = '0;
		frame_index = 0;
		failures = 0;
		frames_seen = 0;
		results_checked = 0;
	endfunction

	function void complain(string what, logic signed [63:0] want, logic signed [63:0] got);
		failures++;
		if (failures <= 10) begin
			$display("Mismatch on %s: expected %0d, got %0d", what, want, got);
		end
	endfunction

	function void set_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			slfo_pkg::REG_FADE_START: begin
				start_units = value[15:0];
			end
			slfo_pkg::REG_FADE_LENGTH: begin
				length_units = value[15:0];
			end
			slfo_pkg::REG_CLIP_FRAMES: begin
				clip_frames = value[25:0];
			end
			default: begin
			end
		endcase
	endfunction

	function logic [31:0] register_value(logic [1:0] idx);
		logic [31:0] value;
		value = '0;
		case (idx)
			slfo_pkg::REG_FADE_START: begin
				value = 32'(start_units);
			end
			slfo_pkg::REG_FADE_LENGTH: begin
				value = 32'(length_units);
			end
			slfo_pkg::REG_CLIP_FRAMES: begin
				value = 32'(clip_frames);
			end
			default: begin
			end
		endcase
		return value;
	endfunction

	function stereo_frame_t faded_frame(logic first, logic signed [15:0] l,
		logic signed [15:0] r);
		longint n;
		longint fade_start;
		longint fade_len;
		longint offset;
		longint gain;
		longint index_max;
		stereo_frame_t res;
		index_max = (longint'(1) << slfo_pkg::IDX_W) - 1;
		n = first ? 0 : frame_index;
		fade_start = longint'(start_units) * frames_per_unit;
		fade_len = longint'(length_units) * frames_per_unit;
		res.left = l;
		res.right = r;
		if (longint'(clip_frames) >= fade_start + fade_len && n >= fade_start) begin
			offset = n - fade_start;
			if (offset < fade_len) begin
				gain = fade_len - offset;
				res.left = 16'(longint'(l) * gain / fade_len);
				res.right = 16'(longint'(r) * gain / fade_len);
			end else begin
				res = '0;
			end
		end
		frame_index = (n < index_max) ? n + 1 : index_max;
		return res;
	endfunction

	function void note_frame(logic first, logic signed [15:0] l, logic signed [15:0] r);
		pending_frames.push_back(faded_frame(first, l, r));
		frames_seen++;
	endfunction

	function void check_frame(logic signed [15:0] l, logic signed [15:0] r);
		stereo_frame_t want;
		if (pending_frames.size() == 0) begin
			complain("result with no frame pending", 0, {l, r});
		end else begin
			want = pending_frames.pop_front();
			results_checked++;
			if (l !== want.left) begin
				complain("left_out", want.left, l);
			end
			if (r !== want.right) begin
				complain("right_out", want.right, r);
			end
		end
	endfunction
endclass

module stereo_linear_fade_out_tb;
	import slfo_pkg::*;

	localparam int FramesPerUnit = 441;
	localparam int SampleBits = 16;
	localparam int ClipFramesMax = (1 << IDX_W) - 1;
	localparam int SettleCycles = 2 * SampleBits + 20;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	slfo_in_if #(.W(SampleBits)) frame_if ();
	slfo_out_if #(.W(SampleBits)) faded_if ();

	stereo_linear_fade_out #(
		.FRAMES_PER_UNIT(FramesPerUnit),
		.SAMPLE_BITS(SampleBits)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_if),
		.faded(faded_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	fade_scoreboard sb;
	bit idling = 1'b0;
	int hold_off_cycles = 0;
	int stall_left = 0;
	int settings_count = 0;

	initial begin
		frame_if.valid = 1'b0;
		frame_if.first_frame = 1'b0;
		frame_if.left_in = '0;
		frame_if.right_in = '0;
		faded_if.ready = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && frame_if.valid && frame_if.ready) begin
			sb.note_frame(frame_if.first_frame, frame_if.left_in, frame_if.right_in);
		end
		if (arst_n && faded_if.valid && faded_if.ready) begin
			sb.check_frame(faded_if.left_out, faded_if.right_out);
		end
	end

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			faded_if.ready = 1'b0;
			hold_off_cycles--;
		end else if (stall_left > 0) begin
			faded_if.ready = 1'b0;
			stall_left--;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			faded_if.ready = 1'b0;
			stall_left = $urandom_range(0, 15);
		end else begin
			faded_if.ready = 1'b1;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic reg_check(input logic [1:0] idx);
		logic [31:0] value;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		value = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (value !== sb.register_value(idx)) begin
			sb.complain("register read-back", sb.register_value(idx), value);
		end
	endtask

	task automatic configure(input int start_units, input int length_units, input int clip);
		reg_write(REG_FADE_START, 32'(start_units));
		reg_write(REG_FADE_LENGTH, 32'(length_units));
		reg_write(REG_CLIP_FRAMES, 32'(clip));
		reg_check(REG_FADE_START);
		reg_check(REG_FADE_LENGTH);
		reg_check(REG_CLIP_FRAMES);
		settings_count++;
	endtask

	task automatic send_frame(input logic first, input logic signed [15:0] l,
		input logic signed [15:0] r);
		int gap;
		@(negedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			frame_if.valid = 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		frame_if.valid = 1'b1;
		frame_if.first_frame = first;
		frame_if.left_in = l;
		frame_if.right_in = r;
		@(posedge clk);
		while (!frame_if.ready) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_sample();
		logic signed [15:0] s;
		s = 16'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 4))
				0: s = 16'sh8000;
				1: s = 16'sh7fff;
				2: s = 16'sh0000;
				3: s = -16'sd1;
				default: s = 16'sd1;
			endcase
		end
		return s;
	endfunction

	task automatic play_frames(input int count, input int restart_one_in, input bit start_clip);
		logic first;
		for (int i = 0; i < count; i++) begin
			first = (i == 0 && start_clip) ||
				(restart_one_in > 0 && $urandom_range(1, restart_one_in) == 1);
			send_frame(first, random_sample(), random_sample());
		end
	endtask

	task automatic drain();
		@(negedge clk);
		frame_if.valid = 1'b0;
		@(posedge clk);
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic random_setting();
		int start_units;
		int length_units;
		int edge_frames;
		int clip;
		case ($urandom_range(0, 3))
			0: start_units = 0;
			1: start_units = 1;
			2: start_units = $urandom_range(0, 65535);
			default: start_units = 65535;
		endcase
		case ($urandom_range(0, 3))
			0: length_units = 0;
			1: length_units = $urandom_range(1, 2);
			2: length_units = $urandom_range(0, 65535);
			default: length_units = 65535;
		endcase
		edge_frames = (start_units + length_units) * FramesPerUnit;
		case ($urandom_range(0, 3))
			0: clip = edge_frames;
			1: clip = (edge_frames > 0) ? edge_frames - 1 : 0;
			2: clip = ClipFramesMax;
			default: clip = $urandom_range(0, ClipFramesMax);
		endcase
		configure(start_units, length_units, clip);
	endtask

	initial begin
		sb = new(FramesPerUnit);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		reg_check(REG_FADE_START);
		reg_check(REG_FADE_LENGTH);
		reg_check(REG_CLIP_FRAMES);

		// With everything at zero there is no fade and every frame is silenced.
		send_frame(1'b1, 16'sh7fff, 16'sh8000);
		send_frame(1'b0, 16'sh8000, 16'sh7fff);
		send_frame(1'b0, 16'sh0000, -16'sd1);
		send_frame(1'b0, 16'sd1, 16'sh0000);
		drain();

		configure(0, 1, FramesPerUnit);
		send_frame(1'b1, 16'sh7fff, 16'sh8000);
		send_frame(1'b0, 16'sh8000, 16'sh7fff);
		send_frame(1'b0, -16'sd1, 16'sd1);
		send_frame(1'b0, 16'sh5555, 16'shaaaa);
		send_frame(1'b0, -16'sd2, 16'sd2);
		drain();

		configure(1, 0, FramesPerUnit);
		send_frame(1'b1, 16'sh8000, 16'sh7fff);
		send_frame(1'b0, 16'sd12345, -16'sd12345);
		drain();

		configure(0, 1, FramesPerUnit - 1);
		send_frame(1'b1, 16'sh7fff, 16'sh8000);
		send_frame(1'b0, 16'sh8000, 16'sh7fff);
		send_frame(1'b0, 16'sd100, -16'sd100);
		drain();

		configure(65535, 65535, ClipFramesMax);
		send_frame(1'b1, 16'sh7fff, 16'sh8000);
		send_frame(1'b0, 16'sh8000, 16'sh7fff);
		drain();

		configure(0, 65535, ClipFramesMax);
		send_frame(1'b1, 16'sh7fff, 16'sh8000);
		send_frame(1'b0, 16'sh8000, 16'sh7fff);
		send_frame(1'b0, -16'sd1, 16'sd1);
		drain();

		idling = 1'b1;
		configure(0, 1, FramesPerUnit);
		play_frames(450, 0, 1'b1);
		drain();

		// The count carries on from the long clip, so the first frames here are past the end.
		configure(1, 0, FramesPerUnit);
		hold_off_cycles = 300;
		play_frames(40, 10, 1'b0);
		drain();

		configure(0, 2, 2 * FramesPerUnit - 1);
		play_frames(40, 20, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			random_setting();
			if (p % 2 == 0) begin
				reg_write(REG_SPARE, $urandom);
				reg_check(REG_FADE_START);
				reg_check(REG_FADE_LENGTH);
				reg_check(REG_CLIP_FRAMES);
			end
			play_frames(30, 15, 1'($urandom_range(0, 1)));
			drain();
		end

		idling = 1'b0;
		configure(0, 2, ClipFramesMax);
		play_frames(40, 0, 1'b1);
		drain();

		$display("Covered %0d frames and %0d checked transactions over %0d register settings,",
			sb.frames_seen, sb.results_checked, settings_count);
		$display("including a long output hold-off and a full fade into silence.");
		if (sb.failures == 0 && sb.pending_frames.size() == 0) begin
			$display("PASS stereo_linear_fade_out");
		end else begin
			$display("FAIL stereo_linear_fade_out");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL stereo_linear_fade_out");
		$finish;
	end
endmodule
